>>> design/segment_intersection_test_defines.svh
// Assertion helpers for the checker of the segment intersection block.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SIT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define SIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sit_pkg.sv
`default_nettype none

package sit_pkg;

  // Coordinate width: signed fixed point, 22 fraction bits.
  localparam int COORD_BITS_DEF = 32;

endpackage

`default_nettype wire

>>> design/sit_diff.sv
`default_nettype none

module sit_diff #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COORD_BITS-1:0] a_lat,
  input  logic signed [COORD_BITS-1:0] a_lon,
  input  logic signed [COORD_BITS-1:0] b_lat,
  input  logic signed [COORD_BITS-1:0] b_lon,
  input  logic signed [COORD_BITS-1:0] c_lat,
  input  logic signed [COORD_BITS-1:0] c_lon,
  input  logic signed [COORD_BITS-1:0] d_lat,
  input  logic signed [COORD_BITS-1:0] d_lon,
  input  logic                         dn_ready,
  output logic                         dn_valid,
  output logic signed [COORD_BITS:0]   q_lat,
  output logic signed [COORD_BITS:0]   q_lon,
  output logic signed [COORD_BITS:0]   r_lat,
  output logic signed [COORD_BITS:0]   r_lon,
  output logic signed [COORD_BITS:0]   s_lat,
  output logic signed [COORD_BITS:0]   s_lon,
  output logic                         coll
);
  import sit_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic                 valid_r;
  logic signed [DW-1:0] q_lat_r, q_lon_r, r_lat_r, r_lon_r, s_lat_r, s_lon_r;
  logic signed [DW-1:0] q_lat_nxt, q_lon_nxt, r_lat_nxt, r_lon_nxt, s_lat_nxt, s_lon_nxt;
  logic                 coll_r, coll_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    q_lat_nxt = {c_lat[COORD_BITS-1], c_lat} - {a_lat[COORD_BITS-1], a_lat};
    q_lon_nxt = {c_lon[COORD_BITS-1], c_lon} - {a_lon[COORD_BITS-1], a_lon};
    r_lat_nxt = {b_lat[COORD_BITS-1], b_lat} - {a_lat[COORD_BITS-1], a_lat};
    r_lon_nxt = {b_lon[COORD_BITS-1], b_lon} - {a_lon[COORD_BITS-1], a_lon};
    s_lat_nxt = {d_lat[COORD_BITS-1], d_lat} - {c_lat[COORD_BITS-1], c_lat};
    s_lon_nxt = {d_lon[COORD_BITS-1], d_lon} - {c_lon[COORD_BITS-1], c_lon};
    // C in [lower end, upper end) of A-B in either coordinate
    coll_nxt  = ((c_lat < a_lat) != (c_lat < b_lat)) ||
                ((c_lon < a_lon) != (c_lon < b_lon));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      q_lat_r <= q_lat_nxt;
      q_lon_r <= q_lon_nxt;
      r_lat_r <= r_lat_nxt;
      r_lon_r <= r_lon_nxt;
      s_lat_r <= s_lat_nxt;
      s_lon_r <= s_lon_nxt;
      coll_r  <= coll_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign q_lat    = q_lat_r;
  assign q_lon    = q_lon_r;
  assign r_lat    = r_lat_r;
  assign r_lon    = r_lon_r;
  assign s_lat    = s_lat_r;
  assign s_lon    = s_lon_r;
  assign coll     = coll_r;

endmodule

`default_nettype wire

>>> design/sit_mul.sv
`default_nettype none

module sit_mul #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [COORD_BITS:0]        q_lat,
  input  logic signed [COORD_BITS:0]        q_lon,
  input  logic signed [COORD_BITS:0]        r_lat,
  input  logic signed [COORD_BITS:0]        r_lon,
  input  logic signed [COORD_BITS:0]        s_lat,
  input  logic signed [COORD_BITS:0]        s_lon,
  input  logic                              coll_in,
  input  logic                              dn_ready,
  output logic                              dn_valid,
  output logic signed [2*COORD_BITS+1:0]    p_qr_a,
  output logic signed [2*COORD_BITS+1:0]    p_qr_b,
  output logic signed [2*COORD_BITS+1:0]    p_qs_a,
  output logic signed [2*COORD_BITS+1:0]    p_qs_b,
  output logic signed [2*COORD_BITS+1:0]    p_rs_a,
  output logic signed [2*COORD_BITS+1:0]    p_rs_b,
  output logic                              coll
);
  import sit_pkg::*;

  localparam int PW = 2 * (COORD_BITS + 1);

  logic                 valid_r;
  logic signed [PW-1:0] p_qr_a_r, p_qr_b_r, p_qs_a_r, p_qs_b_r, p_rs_a_r, p_rs_b_r;
  logic signed [PW-1:0] p_qr_a_nxt, p_qr_b_nxt, p_qs_a_nxt, p_qs_b_nxt;
  logic signed [PW-1:0] p_rs_a_nxt, p_rs_b_nxt;
  logic                 coll_r;

  assign up_ready = !valid_r || dn_ready;

  // u x v = u.lat * v.lon - u.lon * v.lat
  always_comb begin
    p_qr_a_nxt = q_lat * r_lon;
    p_qr_b_nxt = q_lon * r_lat;
    p_qs_a_nxt = q_lat * s_lon;
    p_qs_b_nxt = q_lon * s_lat;
    p_rs_a_nxt = r_lat * s_lon;
    p_rs_b_nxt = r_lon * s_lat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      p_qr_a_r <= p_qr_a_nxt;
      p_qr_b_r <= p_qr_b_nxt;
      p_qs_a_r <= p_qs_a_nxt;
      p_qs_b_r <= p_qs_b_nxt;
      p_rs_a_r <= p_rs_a_nxt;
      p_rs_b_r <= p_rs_b_nxt;
      coll_r   <= coll_in;
    end
  end

  assign dn_valid = valid_r;
  assign p_qr_a   = p_qr_a_r;
  assign p_qr_b   = p_qr_b_r;
  assign p_qs_a   = p_qs_a_r;
  assign p_qs_b   = p_qs_b_r;
  assign p_rs_a   = p_rs_a_r;
  assign p_rs_b   = p_rs_b_r;
  assign coll     = coll_r;

endmodule

`default_nettype wire

>>> design/sit_cross.sv
`default_nettype none

module sit_cross #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [2*COORD_BITS+1:0] p_qr_a,
  input  logic signed [2*COORD_BITS+1:0] p_qr_b,
  input  logic signed [2*COORD_BITS+1:0] p_qs_a,
  input  logic signed [2*COORD_BITS+1:0] p_qs_b,
  input  logic signed [2*COORD_BITS+1:0] p_rs_a,
  input  logic signed [2*COORD_BITS+1:0] p_rs_b,
  input  logic                           coll_in,
  input  logic                           dn_ready,
  output logic                           dn_valid,
  output logic signed [2*COORD_BITS+2:0] x_qr,
  output logic signed [2*COORD_BITS+2:0] x_qs,
  output logic signed [2*COORD_BITS+2:0] x_rs,
  output logic                           coll
);
  import sit_pkg::*;

  localparam int XW = 2 * COORD_BITS + 3;

  logic                 valid_r;
  logic signed [XW-1:0] x_qr_r, x_qs_r, x_rs_r;
  logic signed [XW-1:0] x_qr_nxt, x_qs_nxt, x_rs_nxt;
  logic                 coll_r;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    x_qr_nxt = XW'(p_qr_a) - XW'(p_qr_b);
    x_qs_nxt = XW'(p_qs_a) - XW'(p_qs_b);
    x_rs_nxt = XW'(p_rs_a) - XW'(p_rs_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_qr_r <= x_qr_nxt;
      x_qs_r <= x_qs_nxt;
      x_rs_r <= x_rs_nxt;
      coll_r <= coll_in;
    end
  end

  assign dn_valid = valid_r;
  assign x_qr     = x_qr_r;
  assign x_qs     = x_qs_r;
  assign x_rs     = x_rs_r;
  assign coll     = coll_r;

endmodule

`default_nettype wire

>>> design/sit_cmp.sv
`default_nettype none

module sit_cmp #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic signed [2*COORD_BITS+2:0] x_qr,
  input  logic signed [2*COORD_BITS+2:0] x_qs,
  input  logic signed [2*COORD_BITS+2:0] x_rs,
  input  logic                           coll_in,
  input  logic                           dn_stall,
  output logic                           dn_valid,
  output logic                           hit
);
  import sit_pkg::*;

  localparam int XW = 2 * COORD_BITS + 3;

  // normalise stage
  logic                 nv_r;
  logic                 n_ready;
  logic signed [XW-1:0] n_qr_r, n_qs_r, n_rs_r;
  logic signed [XW-1:0] n_qr_nxt, n_qs_nxt, n_rs_nxt;
  logic                 qr_zero_r, rs_zero_r, coll_r;

  // output stage
  logic                 ov_r;
  logic                 o_ready;
  logic                 hit_r, hit_nxt;

  assign o_ready  = !ov_r || !dn_stall;
  assign n_ready  = !nv_r || o_ready;
  assign up_ready = n_ready;

  // Flip every term when r x s is negative so the bounds read 0 <= t, u <= r x s.
  always_comb begin
    if (x_rs[XW-1]) begin
      n_qr_nxt = -x_qr;
      n_qs_nxt = -x_qs;
      n_rs_nxt = -x_rs;
    end else begin
      n_qr_nxt = x_qr;
      n_qs_nxt = x_qs;
      n_rs_nxt = x_rs;
    end
  end

  always_comb begin
    if (qr_zero_r) begin
      hit_nxt = coll_r;
    end else if (rs_zero_r) begin
      hit_nxt = 1'b0;
    end else begin
      hit_nxt = !n_qs_r[XW-1] && (n_qs_r <= n_rs_r) &&
                !n_qr_r[XW-1] && (n_qr_r <= n_rs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (n_ready) begin
        nv_r <= up_valid;
      end
      if (o_ready) begin
        ov_r <= nv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_ready && up_valid) begin
      n_qr_r    <= n_qr_nxt;
      n_qs_r    <= n_qs_nxt;
      n_rs_r    <= n_rs_nxt;
      qr_zero_r <= (x_qr == '0);
      rs_zero_r <= (x_rs == '0);
      coll_r    <= coll_in;
    end
    if (o_ready && nv_r) begin
      hit_r <= hit_nxt;
    end
  end

  assign dn_valid = ov_r;
  assign hit      = hit_r;

endmodule

`default_nettype wire

>>> design/segment_intersection_test.sv
// Segment intersection test for two segments A-B and C-D.
//
// Input channel (in_*): one item carries the four end points, each coordinate
// signed fixed point with 22 fraction bits. An item is taken at a rising edge
// with in_valid high and in_stall low.
// Result channel (out_*): one item per input item, out_intersects = 1 when the
// segments meet (collinear case: C from the lower end of A-B up to but not
// including the upper end, in either coordinate). The item is taken at an
// edge with out_valid high and out_stall low; while stalled, out_valid and
// out_intersects hold. Pipeline: five register stages (differences,
// products, cross products, sign normalise, compare/output).
// Throughput: one item per cycle unless out_stall backs the pipeline up.
// Each stage advances when it is empty or its successor advances, so bubbles
// are squeezed out and in_stall rises only once every stage is full and the
// output is stalled.
// Reset (rst_n low, synchronous) clears every stage valid bit; no result is
// pending afterwards and the block takes an item at once.
`default_nettype none

module segment_intersection_test #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_lat,
  input  logic signed [COORD_BITS-1:0] in_a_lon,
  input  logic signed [COORD_BITS-1:0] in_b_lat,
  input  logic signed [COORD_BITS-1:0] in_b_lon,
  input  logic signed [COORD_BITS-1:0] in_c_lat,
  input  logic signed [COORD_BITS-1:0] in_c_lon,
  input  logic signed [COORD_BITS-1:0] in_d_lat,
  input  logic signed [COORD_BITS-1:0] in_d_lon,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_intersects
);
  import sit_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = 2 * COORD_BITS + 3;

  // stage 1 -> 2: differences q = C - A, r = B - A, s = D - C
  logic                 d_valid, d_ready_up, m_ready_up;
  logic signed [DW-1:0] q_lat, q_lon, r_lat, r_lon, s_lat, s_lon;
  logic                 d_coll;

  // stage 2 -> 3: the six partial products
  logic                 m_valid, c_ready_up;
  logic signed [PW-1:0] p_qr_a, p_qr_b, p_qs_a, p_qs_b, p_rs_a, p_rs_b;
  logic                 m_coll;

  // stage 3 -> 4: cross products
  logic                 c_valid, k_ready_up;
  logic signed [XW-1:0] x_qr, x_qs, x_rs;
  logic                 c_coll;

  assign in_stall = !d_ready_up;

  sit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (d_ready_up),
    .a_lat    (in_a_lat),
    .a_lon    (in_a_lon),
    .b_lat    (in_b_lat),
    .b_lon    (in_b_lon),
    .c_lat    (in_c_lat),
    .c_lon    (in_c_lon),
    .d_lat    (in_d_lat),
    .d_lon    (in_d_lon),
    .dn_ready (m_ready_up),
    .dn_valid (d_valid),
    .q_lat    (q_lat),
    .q_lon    (q_lon),
    .r_lat    (r_lat),
    .r_lon    (r_lon),
    .s_lat    (s_lat),
    .s_lon    (s_lon),
    .coll     (d_coll)
  );

  sit_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d_valid),
    .up_ready (m_ready_up),
    .q_lat    (q_lat),
    .q_lon    (q_lon),
    .r_lat    (r_lat),
    .r_lon    (r_lon),
    .s_lat    (s_lat),
    .s_lon    (s_lon),
    .coll_in  (d_coll),
    .dn_ready (c_ready_up),
    .dn_valid (m_valid),
    .p_qr_a   (p_qr_a),
    .p_qr_b   (p_qr_b),
    .p_qs_a   (p_qs_a),
    .p_qs_b   (p_qs_b),
    .p_rs_a   (p_rs_a),
    .p_rs_b   (p_rs_b),
    .coll     (m_coll)
  );

  sit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (m_valid),
    .up_ready (c_ready_up),
    .p_qr_a   (p_qr_a),
    .p_qr_b   (p_qr_b),
    .p_qs_a   (p_qs_a),
    .p_qs_b   (p_qs_b),
    .p_rs_a   (p_rs_a),
    .p_rs_b   (p_rs_b),
    .coll_in  (m_coll),
    .dn_ready (k_ready_up),
    .dn_valid (c_valid),
    .x_qr     (x_qr),
    .x_qs     (x_qs),
    .x_rs     (x_rs),
    .coll     (c_coll)
  );

  // normalise and compare; the last stage is the output register
  sit_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid),
    .up_ready (k_ready_up),
    .x_qr     (x_qr),
    .x_qs     (x_qs),
    .x_rs     (x_rs),
    .coll_in  (c_coll),
    .dn_stall (out_stall),
    .dn_valid (out_valid),
    .hit      (out_intersects)
  );

endmodule

`default_nettype wire

>>> design/sit_checker.sv
`default_nettype none
`include "segment_intersection_test_defines.svh"

module sit_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_intersects
);

  // a stalled result item holds
  `SIT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_intersects), "result item changed while stalled")

  // input back-pressure only when a result is waiting and stalled
  `SIT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall && (in_valid || !in_valid), "input stalled without a stalled result")

  // nothing pending straight after reset
  `SIT_ASSERT_NOW(a_reset_empty, !$past(rst_n), !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind segment_intersection_test sit_checker u_sit_checker (.*);

`default_nettype wire

>>> test/tb_segment_intersection_test.sv
`default_nettype none

module tb_segment_intersection_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = sit_pkg::COORD_BITS_DEF;
  // 1.0 in the coordinate format (22 fraction bits)
  localparam int ONE = 1 << 22;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int N_RANDOM_PHASE = 200;
  // five register stages; keep clocking after the scoreboard empties before the verdict
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX = 10;

  // One item on the input channel: the four end points A, B, C, D.
  typedef struct packed {
    logic [CW-1:0] a_lat, a_lon, b_lat, b_lon, c_lat, c_lon, d_lat, d_lon;
  } seg_pair_t;

  // Cross products need 2*CW+3 bits; hold everything exactly in 128 bits.
  typedef logic signed [127:0] wide_t;

  // Queue of predicted intersection bits, one per accepted item, in order.
  class intersect_scoreboard;
    logic expected_q[$];
    int unsigned n_pairs, n_checked, n_hits, n_collinear, n_parallel, n_errors;

    function logic predict_meet(seg_pair_t p, output bit is_collinear,
                                output bit is_parallel);
      wide_t ax, ay, bx, by, cx, cy, dx, dy;
      wide_t qx, qy, rx, ry, sx, sy, qr, qs, rs;
      ax = $signed(p.a_lat); ay = $signed(p.a_lon);
      bx = $signed(p.b_lat); by = $signed(p.b_lon);
      cx = $signed(p.c_lat); cy = $signed(p.c_lon);
      dx = $signed(p.d_lat); dy = $signed(p.d_lon);
      qx = cx - ax; qy = cy - ay;
      rx = bx - ax; ry = by - ay;
      sx = dx - cx; sy = dy - cy;
      qr = qx * ry - qy * rx;
      qs = qx * sy - qy * sx;
      rs = rx * sy - ry * sx;
      is_collinear = (qr == 0);
      is_parallel = 1'b0;
      // collinear: C in [lower end, upper end) of A-B in either coordinate
      if (is_collinear)
        return ((cx < ax) != (cx < bx)) || ((cy < ay) != (cy < by));
      if (rs == 0) begin
        is_parallel = 1'b1;
        return 1'b0;
      end
      // fold the sign of r x s so both t and u become plain range checks
      if (rs < 0) begin
        rs = -rs;
        qs = -qs;
        qr = -qr;
      end
      return (qs >= 0) && (qs <= rs) && (qr >= 0) && (qr <= rs);
    endfunction

    function void note_pair(seg_pair_t p);
      bit col, par;
      logic hit;
      hit = predict_meet(p, col, par);
      expected_q.insert(expected_q.size(), hit);
      n_pairs++;
      n_hits += hit;
      n_collinear += col;
      n_parallel += par;
    endfunction

    function void check_result(logic got);
      logic exp_bit;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("ERROR: result %b arrived with nothing pending", got);
        return;
      end
      exp_bit = expected_q.pop_front();
      n_checked++;
      if (got !== exp_bit) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("ERROR: result %0d intersects expected %b actual %b",
                   n_checked, exp_bit, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_a_lat = '0, in_a_lon = '0, in_b_lat = '0, in_b_lon = '0;
  logic signed [CW-1:0] in_c_lat = '0, in_c_lon = '0, in_d_lat = '0, in_d_lon = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_intersects;

  int send_idle = 0;
  int recv_idle = 0;
  int unsigned cycles = 0;

  intersect_scoreboard sb = new();

  segment_intersection_test #(.COORD_BITS(CW)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_a_lat       (in_a_lat),
    .in_a_lon       (in_a_lon),
    .in_b_lat       (in_b_lat),
    .in_b_lon       (in_b_lon),
    .in_c_lat       (in_c_lat),
    .in_c_lon       (in_c_lon),
    .in_d_lat       (in_d_lat),
    .in_d_lon       (in_d_lon),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_intersects (out_intersects)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if the pipeline ever wedges.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycles, sb.expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: stall at random at the current idle rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Monitors: sample both handshakes on the edge that completes them.
  // Inputs are driven by nonblocking assignment, so the values seen here are
  // the ones the block took at this edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_pair({in_a_lat, in_a_lon, in_b_lat, in_b_lon,
                    in_c_lat, in_c_lon, in_d_lat, in_d_lon});
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_intersects);
  end

  function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p = {ax[CW-1:0], ay[CW-1:0], bx[CW-1:0], by[CW-1:0],
         cx[CW-1:0], cy[CW-1:0], dx[CW-1:0], dy[CW-1:0]};
    return p;
  endfunction

  // Uniform integer in [-lim, lim]; lim stays well below 2**30.
  function automatic int pm_rand(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(4))
      0: return int'(C_MIN);
      1: return int'(C_MAX);
      2: return 0;
      3: return -1;
      default: return int'($urandom);
    endcase
  endfunction

  // Random segment pair. Mix fully random points (which rarely meet) with
  // shaped cases: small grids, collinear, parallel and crossing constructions.
  function automatic seg_pair_t rand_pair();
    int px, py, qx, qy, ux, uy, vx, vy, k1, k2, k3;
    px = pm_rand(1 << 28); py = pm_rand(1 << 28);
    qx = pm_rand(1 << 28); qy = pm_rand(1 << 28);
    ux = pm_rand(1 << 20); uy = pm_rand(1 << 20);
    vx = pm_rand(1 << 20); vy = pm_rand(1 << 20);
    k1 = pm_rand(4); k2 = pm_rand(4); k3 = pm_rand(4);
    case ($urandom_range(9))
      0, 1: return make_pair($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
      // coarse grid: many touching, collinear and degenerate cases
      2, 3: return make_pair(pm_rand(4) * ONE, pm_rand(4) * ONE,
                             pm_rand(4) * ONE, pm_rand(4) * ONE,
                             pm_rand(4) * ONE, pm_rand(4) * ONE,
                             pm_rand(4) * ONE, pm_rand(4) * ONE);
      // C on the line through A and B; D either on it too or anywhere
      4: begin
        if ($urandom_range(1))
          return make_pair(px, py, px + k1 * ux, py + k1 * uy,
                           px + k2 * ux, py + k2 * uy,
                           px + (k2 + k3) * ux, py + (k2 + k3) * uy);
        return make_pair(px, py, px + k1 * ux, py + k1 * uy,
                         px + k2 * ux, py + k2 * uy, qx, qy);
      end
      // C-D parallel to A-B, off the line
      5: return make_pair(px, py, px + ux, py + uy,
                          qx, qy, qx + k1 * ux, qy + k1 * uy);
      // two segments through a common point; zero reach puts it on an end
      6, 7: return make_pair(px - int'($urandom_range(4)) * ux,
                             py - int'($urandom_range(4)) * uy,
                             px + int'($urandom_range(4)) * ux,
                             py + int'($urandom_range(4)) * uy,
                             px - int'($urandom_range(4)) * vx,
                             py - int'($urandom_range(4)) * vy,
                             px + int'($urandom_range(4)) * vx,
                             py + int'($urandom_range(4)) * vy);
      8: return make_pair(pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme());
      // half-unit grid: near misses just past the ends
      default: return make_pair(pm_rand(8) * (ONE / 2), pm_rand(8) * (ONE / 2),
                                pm_rand(8) * (ONE / 2), pm_rand(8) * (ONE / 2),
                                pm_rand(8) * (ONE / 2), pm_rand(8) * (ONE / 2),
                                pm_rand(8) * (ONE / 2), pm_rand(8) * (ONE / 2));
    endcase
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold it until
  // the block takes it.
  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_a_lat, in_a_lon, in_b_lat, in_b_lon,
     in_c_lat, in_c_lon, in_d_lat, in_d_lon} <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    // hold reset, then release it for good
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      // sender and receiver idle rates: one busy pattern, its mirror, none
      case (ph)
        0: begin send_idle = 32; recv_idle = 46; end
        1: begin send_idle = 46; recv_idle = 32; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase

      if (ph == 0) begin
        // plain crossing X (r x s negative), then the same with A-B reversed (r x s positive)
        send_pair(make_pair(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0));
        send_pair(make_pair(2 * ONE, 2 * ONE, 0, 0, 0, 2 * ONE, 2 * ONE, 0));
        // parallel, apart
        send_pair(make_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE));
        // C on A-B strictly inside: collinear rule gives a hit
        send_pair(make_pair(0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE));
        // D touches the interior of A-B: u exactly one
        send_pair(make_pair(0, 0, 2 * ONE, 0, ONE, -ONE, ONE, 0));
        // C on end B: q x r is zero, so the collinear rule applies and misses
        send_pair(make_pair(0, 0, 2 * ONE, 0, 2 * ONE, 0, 3 * ONE, ONE));
        // past an end: t equals two
        send_pair(make_pair(0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE));
        // collinear with C beyond B: no hit
        send_pair(make_pair(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE));
        // collinear with C equal to A: counts under the strict sign rule
        send_pair(make_pair(0, 0, 2 * ONE, 2 * ONE, 0, 0, ONE, ONE));
        // A, B and C all the same point: no hit
        send_pair(make_pair(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE,
                            5 * ONE, 5 * ONE, 7 * ONE, 9 * ONE));
        // zero-length C-D off the line of A-B
        send_pair(make_pair(0, 0, 2 * ONE, 0, ONE, ONE, ONE, ONE));
        // zero-length A-B away from C
        send_pair(make_pair(ONE, ONE, ONE, ONE, 0, 0, 3 * ONE, 2 * ONE));
        // coordinate extremes
        send_pair(make_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_pair(make_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_pair(make_pair(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
        send_pair(make_pair(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
        send_pair(make_pair(C_MIN, 0, C_MAX, 0, C_MAX, 0, C_MIN, 0));
        send_pair(make_pair(-1, -1, 0, 0, C_MIN, C_MAX, -1, 0));
        // alternating bit patterns on every field
        send_pair(make_pair(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                            32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'h55555555));
        send_pair(make_pair(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                            32'h55555555, 32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA));
      end

      repeat (N_RANDOM_PHASE) send_pair(rand_pair());
    end

    // drop valid and let the pipeline drain
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d segment pairs over three idle patterns;",
             sb.n_checked, sb.n_pairs);
    $display("%0d meeting, %0d collinear, %0d parallel; %0d mismatches.",
             sb.n_hits, sb.n_collinear, sb.n_parallel, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> segment_intersection_test.f
+incdir+design
design/sit_pkg.sv
design/sit_diff.sv
design/sit_mul.sv
design/sit_cross.sv
design/sit_cmp.sv
design/segment_intersection_test.sv
design/sit_checker.sv
test/tb_segment_intersection_test.sv
